>>> hw/rtl/alle_pkg.sv
// ----------------------------------------------------------------------------
// alle_pkg: shared types and codes of the array linked list engine
// Opcodes, status codes, the command kinds passed from the front end to the
// back end, the command record that travels through the queue, and the back-end states.
// ----------------------------------------------------------------------------
package alle_pkg;

    localparam int POS_W       = 6;
    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_INS_HEAD  = 2'd0;
    localparam logic [1:0] OP_INS_AFTER = 2'd1;
    localparam logic [1:0] OP_DEL_AFTER = 2'd2;
    localparam logic [1:0] OP_TRAVERSE  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef enum logic [2:0] {
        K_INS_HEAD,
        K_INS_AFTER,
        K_DEL_AFTER,
        K_DEL_HEAD,
        K_TRAVERSE,
        K_REJECT
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [1:0]         status;   // status of a rejected command
        logic [POS_W-1:0]   pos;
        logic [DATA_W-1:0]  value;
    } t_cmd;

    typedef enum logic [2:0] {
        B_IDLE,
        B_INS_LINK,
        B_DEL_FIRST,
        B_DEL_SECOND,
        B_HEAD_DEL,
        B_TRAV
    } t_bstate;

endpackage

>>> hw/rtl/alle_ram.sv
// ----------------------------------------------------------------------------
// alle_ram: generic single write, single read RAM
// One write port and one read port; read data is registered and returns the
// old contents when the same address is written in that cycle.
// ----------------------------------------------------------------------------
module alle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/alle_front.sv
// ----------------------------------------------------------------------------
// alle_front: command front end
// Classify each accepted command, catch full-table and bad-position cases
// and keep the slot allocation count.
// ----------------------------------------------------------------------------
module alle_front #(
    parameter int NODE_SLOTS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [1:0]                  i_opcode,
    input  logic [alle_pkg::POS_W-1:0]  i_position,
    input  logic [alle_pkg::DATA_W-1:0] i_value,
    output logic                        o_push,
    output alle_pkg::t_cmd              o_cmd
);

    localparam int NS_W  = $clog2(NODE_SLOTS + 1);
    localparam int CMP_W = (NS_W > alle_pkg::POS_W) ? NS_W : alle_pkg::POS_W;

    logic [NS_W-1:0]  r_next_slot;
    logic [NS_W-1:0]  n_next_slot;
    logic             full;
    logic             pos_zero;
    logic             pos_beyond;
    alle_pkg::t_cmd   cmd;

    assign full       = (r_next_slot == NS_W'(NODE_SLOTS));
    assign pos_zero   = (i_position == '0);
    assign pos_beyond = (CMP_W'(i_position) >= CMP_W'(r_next_slot));

    always_comb begin
        cmd.kind    = alle_pkg::K_REJECT;
        cmd.status  = alle_pkg::ST_OK;
        cmd.pos     = i_position;
        cmd.value   = i_value;
        n_next_slot = r_next_slot;
        unique case (i_opcode)
            alle_pkg::OP_INS_HEAD: begin
                if (full) begin
                    cmd.status = alle_pkg::ST_FULL;
                end else begin
                    cmd.kind    = alle_pkg::K_INS_HEAD;
                    n_next_slot = NS_W'(r_next_slot + 1'b1);
                end
            end
            alle_pkg::OP_INS_AFTER: begin
                if (pos_zero || pos_beyond) begin
                    cmd.status = alle_pkg::ST_BADPOS;
                end else if (full) begin
                    cmd.status = alle_pkg::ST_FULL;
                end else begin
                    cmd.kind    = alle_pkg::K_INS_AFTER;
                    n_next_slot = NS_W'(r_next_slot + 1'b1);
                end
            end
            alle_pkg::OP_DEL_AFTER: begin
                if (pos_zero) begin
                    cmd.kind = alle_pkg::K_DEL_HEAD;
                end else if (pos_beyond) begin
                    cmd.status = alle_pkg::ST_BADPOS;
                end else begin
                    cmd.kind = alle_pkg::K_DEL_AFTER;
                end
            end
            default: begin
                cmd.kind = alle_pkg::K_TRAVERSE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_slot <= NS_W'(1);
        end else if (i_accept) begin
            r_next_slot <= n_next_slot;
        end
    end

    assign o_push = i_accept;
    assign o_cmd  = cmd;

`ifndef SYNTH
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_slot != '0) && (r_next_slot <= NS_W'(NODE_SLOTS)))
        else $error("allocation count out of range");

    a_slot_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_next_slot))
        else $error("allocation count moved without a transfer");
`endif

endmodule

>>> hw/rtl/alle_queue.sv
// ----------------------------------------------------------------------------
// alle_queue: command queue
// Short FIFO of classified commands between the front end and the back end.
// ----------------------------------------------------------------------------
module alle_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  alle_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output alle_pkg::t_cmd o_cmd
);

    localparam int DEPTH = alle_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    alle_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

>>> hw/rtl/alle_back.sv
// ----------------------------------------------------------------------------
// alle_back: list back end
// Carry out queued commands on the value and link memories and drive the
// result strobe.
// ----------------------------------------------------------------------------
module alle_back #(
    parameter int NODE_SLOTS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  alle_pkg::t_cmd              i_cmd,
    output logic                        o_pop,
    output logic                        o_valid,
    output logic [alle_pkg::DATA_W-1:0] o_data,
    output logic [1:0]                  o_status,
    output logic                        o_last
);

    localparam int SLOT_W = $clog2(NODE_SLOTS);
    localparam int KW     = (SLOT_W > alle_pkg::POS_W) ? SLOT_W : alle_pkg::POS_W;

    alle_pkg::t_bstate         r_state, n_state;
    logic [SLOT_W-1:0]         r_head, n_head;
    logic [SLOT_W-1:0]         r_fill, n_fill;
    logic [SLOT_W-1:0]         r_k, n_k;
    logic                      r_valid, n_valid;
    logic [alle_pkg::DATA_W-1:0] r_data, n_data;
    logic [1:0]                r_status, n_status;
    logic                      r_last, n_last;

    logic [KW-1:0]             k_ext;
    logic [SLOT_W-1:0]         k_addr;
    logic [SLOT_W-1:0]         raddr;
    logic                      l_we;
    logic [SLOT_W-1:0]         l_wa;
    logic [SLOT_W-1:0]         l_wd;
    logic [SLOT_W-1:0]         l_rdata;
    logic                      v_we;
    logic [alle_pkg::DATA_W-1:0] v_rdata;
    logic                      pop;

    assign k_ext  = KW'(i_cmd.pos);
    assign k_addr = k_ext[SLOT_W-1:0];

    alle_ram #(.WIDTH(SLOT_W), .DEPTH(NODE_SLOTS)) u_links (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_wa),
        .i_wdata (l_wd),
        .i_raddr (raddr),
        .o_rdata (l_rdata)
    );

    alle_ram #(.WIDTH(alle_pkg::DATA_W), .DEPTH(NODE_SLOTS)) u_values (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (r_fill),
        .i_wdata (i_cmd.value),
        .i_raddr (raddr),
        .o_rdata (v_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_fill   = r_fill;
        n_k      = r_k;
        n_valid  = 1'b0;
        n_data   = '0;
        n_status = alle_pkg::ST_OK;
        n_last   = 1'b1;
        pop      = 1'b0;
        l_we     = 1'b0;
        l_wa     = r_k;
        l_wd     = r_fill;
        v_we     = 1'b0;
        raddr    = k_addr;
        unique case (r_state)
            alle_pkg::B_IDLE: begin
                if (!i_empty) begin
                    pop = 1'b1;
                    unique case (i_cmd.kind)
                        alle_pkg::K_INS_HEAD: begin
                            v_we    = 1'b1;
                            l_we    = 1'b1;
                            l_wa    = r_fill;
                            l_wd    = r_head;
                            n_head  = r_fill;
                            n_fill  = SLOT_W'(r_fill + 1'b1);
                            n_valid = 1'b1;
                        end
                        alle_pkg::K_INS_AFTER: begin
                            // read old link of k while pointing k at the new slot
                            v_we    = 1'b1;
                            l_we    = 1'b1;
                            l_wa    = k_addr;
                            l_wd    = r_fill;
                            n_k     = r_fill;
                            n_fill  = SLOT_W'(r_fill + 1'b1);
                            n_state = alle_pkg::B_INS_LINK;
                        end
                        alle_pkg::K_DEL_AFTER: begin
                            n_k     = k_addr;
                            n_state = alle_pkg::B_DEL_FIRST;
                        end
                        alle_pkg::K_DEL_HEAD: begin
                            raddr = r_head;
                            if (r_head == '0) begin
                                n_valid  = 1'b1;
                                n_status = alle_pkg::ST_EMPTY;
                            end else begin
                                n_state = alle_pkg::B_HEAD_DEL;
                            end
                        end
                        alle_pkg::K_TRAVERSE: begin
                            raddr = r_head;
                            if (r_head == '0) begin
                                n_valid  = 1'b1;
                                n_status = alle_pkg::ST_EMPTY;
                            end else begin
                                n_state = alle_pkg::B_TRAV;
                            end
                        end
                        default: begin
                            n_valid  = 1'b1;
                            n_status = i_cmd.status;
                        end
                    endcase
                end
            end
            alle_pkg::B_INS_LINK: begin
                l_we    = 1'b1;
                l_wa    = r_k;
                l_wd    = l_rdata;
                n_valid = 1'b1;
                n_state = alle_pkg::B_IDLE;
            end
            alle_pkg::B_DEL_FIRST: begin
                raddr = l_rdata;
                if (l_rdata == '0) begin
                    n_valid  = 1'b1;
                    n_status = alle_pkg::ST_BADPOS;
                    n_state  = alle_pkg::B_IDLE;
                end else begin
                    n_state = alle_pkg::B_DEL_SECOND;
                end
            end
            alle_pkg::B_DEL_SECOND: begin
                l_we    = 1'b1;
                l_wa    = r_k;
                l_wd    = l_rdata;
                n_valid = 1'b1;
                n_state = alle_pkg::B_IDLE;
            end
            alle_pkg::B_HEAD_DEL: begin
                n_head  = l_rdata;
                n_valid = 1'b1;
                n_state = alle_pkg::B_IDLE;
            end
            alle_pkg::B_TRAV: begin
                // emit this node, chase its link
                raddr   = l_rdata;
                n_valid = 1'b1;
                n_data  = v_rdata;
                n_last  = (l_rdata == '0);
                if (l_rdata == '0) begin
                    n_state = alle_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = alle_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= alle_pkg::B_IDLE;
            r_head  <= '0;
            r_fill  <= SLOT_W'(1);
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_data   <= n_data;
        r_status <= n_status;
        r_last   <= n_last;
    end

    assign o_pop    = pop;
    assign o_valid  = r_valid;
    assign o_data   = r_data;
    assign o_status = r_status;
    assign o_last   = r_last;

`ifndef SYNTH
    a_trav_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == alle_pkg::B_TRAV) |=> r_valid)
        else $error("traverse cycle without a result");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last) |-> (r_status == alle_pkg::ST_OK))
        else $error("non-final result with error status");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (r_state == alle_pkg::B_IDLE) && !i_empty)
        else $error("command taken while busy");
`endif

endmodule

>>> hw/rtl/array_linked_list_engine.sv
// ----------------------------------------------------------------------------
// array_linked_list_engine: singly linked list held in value and link RAMs
// Insert at head, insert after node, delete after node and traverse.
// ----------------------------------------------------------------------------
// Commands are taken on start while busy is low and go through a two-entry
// queue, so the front end keeps taking commands while the back end works.
// Results come out at most one per cycle on o_valid and cannot be stalled;
// each command gives exactly one result, except traverse of a non-empty
// list, which gives one per list element with o_last on the final one. The
// back end works one command at a time against a link RAM with one read and
// one write port: insert at head, front-end refusals (table full or position
// not handed out) and delete or traverse on an empty list end in B_IDLE;
// insert after node goes on to B_INS_LINK, delete of the head to B_HEAD_DEL,
// delete after node to B_DEL_FIRST and B_DEL_SECOND (after the tail it ends
// in B_DEL_FIRST), and traverse stays in B_TRAV until the last element. busy
// rises when the queue holds two commands. Slots are numbered from 1 in
// insertion order and never reused; once NODE_SLOTS - 1 slots are handed out
// every insert is refused, with table-full status unless its position is bad.
// The RAMs need no clearing after reset: only handed-out slots are ever read.
// ----------------------------------------------------------------------------
module array_linked_list_engine #(
    parameter int NODE_SLOTS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_opcode,
    input  logic [5:0]                  i_position,
    input  logic signed [31:0]          i_value,
    output logic                        o_valid,
    output logic signed [31:0]          o_data,
    output logic [1:0]                  o_status,
    output logic                        o_last
);

    logic           accept;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;
    alle_pkg::t_cmd front_cmd;
    alle_pkg::t_cmd back_cmd;

    // a transfer happens whenever start is high and the queue has room
    assign busy   = q_full;
    assign accept = start && !q_full;

    // classify and allocate slots
    alle_front #(.NODE_SLOTS(NODE_SLOTS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_opcode   (i_opcode),
        .i_position (i_position),
        .i_value    (i_value),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    // hold commands between the two sides
    alle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (back_cmd)
    );

    // walk and rewrite the list, drive results
    alle_back #(.NODE_SLOTS(NODE_SLOTS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_cmd    (back_cmd),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_data   (o_data),
        .o_status (o_status),
        .o_last   (o_last)
    );

endmodule

>>> test/array_linked_list_engine_tb.sv
// ----------------------------------------------------------------------------
// array_linked_list_engine_tb: self-checking bench for the linked list engine
// Drives insert, delete and traverse commands through the start/busy
// handshake in random bursts. A shadow copy of the list predicts every result,
// and each o_valid result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module array_linked_list_engine_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 64;
    localparam int RANDOM_CMDS = 140;
    localparam int IDLE_LIMIT  = 2000;  // cycles with no transfer and no result
    localparam int TAIL_CYCLES = 20;    // quiet time after the last result
    localparam int SHOW_ERRORS = 10;

    typedef struct {
        logic [1:0]                  op;
        logic [alle_pkg::POS_W-1:0]  pos;
        logic signed [31:0]          val;
        bit                          drain_first;  // hold until all results are in
    } list_cmd_t;

    typedef struct {
        logic signed [31:0] data;
        logic [1:0]         status;
        logic               last;
    } list_resp_t;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               start      = 1'b0;
    logic [1:0]         i_opcode   = alle_pkg::OP_TRAVERSE;
    logic [5:0]         i_position = '0;
    logic signed [31:0] i_value    = '0;
    logic               busy;
    logic               o_valid;
    logic signed [31:0] o_data;
    logic [1:0]         o_status;
    logic               o_last;

    always #10 i_clk = ~i_clk;

    array_linked_list_engine #(
        .NODE_SLOTS (SLOTS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_opcode   (i_opcode),
        .i_position (i_position),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .o_status   (o_status),
        .o_last     (o_last)
    );

    // ------------------------------------------------------------------------
    // Shadow list: its own value/link arrays, head and slot allocator
    // ------------------------------------------------------------------------
    logic signed [31:0]          shadow_vals [SLOTS];
    logic [alle_pkg::POS_W-1:0]  shadow_links [SLOTS];
    int                          shadow_head = 0;
    int                          shadow_next = 1;

    list_cmd_t  pending_cmds[$];   // filled by the stimulus block, drained by the driver
    list_resp_t list_resp_q[$];    // predicted results not yet seen on the outputs

    // Run statistics
    int err_count     = 0;
    int resp_count    = 0;
    int op_count [4]  = '{default: 0};
    int status_count [4] = '{default: 0};
    int longest_walk  = 0;

    // Apply one accepted command to the shadow list and queue its results.
    task automatic apply_list_cmd(input list_cmd_t c);
        int         cur;
        int         nxt;
        int         n;
        logic [1:0] st;
        list_resp_t r;
        st = alle_pkg::ST_OK;
        op_count[c.op]++;
        case (c.op)
            alle_pkg::OP_INS_HEAD: begin
                if (shadow_next >= SLOTS) begin
                    st = alle_pkg::ST_FULL;
                end else begin
                    shadow_vals[shadow_next]  = c.val;
                    shadow_links[shadow_next] = shadow_head[alle_pkg::POS_W-1:0];
                    shadow_head = shadow_next;
                    shadow_next++;
                end
            end
            alle_pkg::OP_INS_AFTER: begin
                // bad position wins over a full table
                if (c.pos == 0 || c.pos >= shadow_next) begin
                    st = alle_pkg::ST_BADPOS;
                end else if (shadow_next >= SLOTS) begin
                    st = alle_pkg::ST_FULL;
                end else begin
                    shadow_vals[shadow_next]  = c.val;
                    shadow_links[shadow_next] = shadow_links[c.pos];
                    shadow_links[c.pos]       = shadow_next[alle_pkg::POS_W-1:0];
                    shadow_next++;
                end
            end
            alle_pkg::OP_DEL_AFTER: begin
                if (c.pos == 0) begin
                    if (shadow_head == 0)
                        st = alle_pkg::ST_EMPTY;
                    else
                        shadow_head = int'(shadow_links[shadow_head]);
                end else if (c.pos >= shadow_next || shadow_links[c.pos] == 0) begin
                    st = alle_pkg::ST_BADPOS;
                end else begin
                    // stale nodes keep their link and are handled like live ones
                    shadow_links[c.pos] = shadow_links[shadow_links[c.pos]];
                end
            end
            default: begin
                st = (shadow_head == 0) ? alle_pkg::ST_EMPTY : alle_pkg::ST_OK;
            end
        endcase
        status_count[st]++;

        if (c.op == alle_pkg::OP_TRAVERSE && shadow_head != 0) begin
            // walk head to tail, capped at SLOTS - 1 elements
            cur = shadow_head;
            n   = 0;
            while (cur != 0 && n < SLOTS - 1) begin
                nxt      = int'(shadow_links[cur]);
                r.data   = shadow_vals[cur];
                r.status = alle_pkg::ST_OK;
                r.last   = (nxt == 0 || n == SLOTS - 2);
                list_resp_q.insert(list_resp_q.size(), r);
                n++;
                cur = nxt;
            end
            if (n > longest_walk)
                longest_walk = n;
        end else begin
            r.data   = 32'sd0;
            r.status = st;
            r.last   = 1'b1;
            list_resp_q.insert(list_resp_q.size(), r);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: present commands in bursts, hold each until the transfer
    // ------------------------------------------------------------------------
    list_cmd_t cur_cmd;
    bit        cmd_taken;
    int        burst_left = 4;
    int        gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            cmd_taken = start && !busy;
            // predict first, so a drain check below sees this transfer's results
            if (cmd_taken)
                apply_list_cmd(cur_cmd);

            if (start && !cmd_taken) begin
                // hold: command still waiting for busy to drop
            end else if (pending_cmds.size() > 0 && gap_left == 0 &&
                         !(pending_cmds[0].drain_first && list_resp_q.size() > 0)) begin
                cur_cmd = pending_cmds.pop_front();
                start      <= 1'b1;
                i_opcode   <= cur_cmd.op;
                i_position <= cur_cmd.pos;
                i_value    <= cur_cmd.val;
                burst_left--;
                if (burst_left <= 0) begin
                    // end of burst: pick the next gap, zero now and then
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                start <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every strobed result must match the oldest prediction
    // ------------------------------------------------------------------------
    list_resp_t want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            resp_count++;
            if (list_resp_q.size() == 0) begin
                err_count++;
                if (err_count <= SHOW_ERRORS)
                    $display("%0t: unexpected result data=%0d status=%0d last=%0b",
                             $realtime, o_data, o_status, o_last);
            end else begin
                want = list_resp_q.pop_front();
                if (o_data !== want.data || o_status !== want.status ||
                    o_last !== want.last) begin
                    err_count++;
                    if (err_count <= SHOW_ERRORS)
                        $display("%0t: mismatch data %0d/%0d status %0d/%0d last %0b/%0b (exp/act)",
                                 $realtime, want.data, o_data, want.status, o_status,
                                 want.last, o_last);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles with neither a command transfer nor a result
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    task automatic add_cmd(input logic [1:0] op, input int pos, input logic signed [31:0] val,
                           input bit drain_first = 1'b0);
        list_cmd_t c;
        c.op          = op;
        c.pos         = pos[alle_pkg::POS_W-1:0];
        c.val         = val;
        c.drain_first = drain_first;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    initial begin
        int  est_slots;
        int  pick;
        int  pos;
        bit  timed_out;
        logic [1:0] op;

        // Directed part: empty list, bad positions, extremes, stale links
        add_cmd(alle_pkg::OP_TRAVERSE,  0, 0);                 // empty traverse
        add_cmd(alle_pkg::OP_DEL_AFTER, 0, 0);                 // delete head of empty list
        add_cmd(alle_pkg::OP_INS_AFTER, 0, 7);                 // insert after node zero
        add_cmd(alle_pkg::OP_INS_AFTER, 5, 7);                 // node not handed out yet
        add_cmd(alle_pkg::OP_DEL_AFTER, 3, 0);                 // delete after missing node
        add_cmd(alle_pkg::OP_INS_HEAD,  0, 32'sh7FFF_FFFF);    // node 1
        add_cmd(alle_pkg::OP_INS_HEAD, 63, 32'sh8000_0000);    // node 2, position ignored
        add_cmd(alle_pkg::OP_INS_AFTER, 1, -32'sd1);           // node 3 at the tail
        add_cmd(alle_pkg::OP_INS_AFTER, 2, 32'sd0);            // node 4 in the middle
        add_cmd(alle_pkg::OP_DEL_AFTER, 3, 0);                 // delete after the tail
        add_cmd(alle_pkg::OP_TRAVERSE, 63, 32'sh5555_AAAA);
        add_cmd(alle_pkg::OP_DEL_AFTER, 4, 0);                 // unlink node 1
        add_cmd(alle_pkg::OP_INS_AFTER, 1, 32'sh1234_5678);    // insert after a removed node
        add_cmd(alle_pkg::OP_DEL_AFTER, 1, 0);                 // delete after a removed node
        add_cmd(alle_pkg::OP_DEL_AFTER, 0, 0);                 // remove the head
        add_cmd(alle_pkg::OP_TRAVERSE,  0, 0);
        add_cmd(alle_pkg::OP_INS_AFTER, 63, -32'sd2);          // far out of range
        add_cmd(alle_pkg::OP_DEL_AFTER, 63, 0);
        add_cmd(alle_pkg::OP_TRAVERSE,  0, 0, 1'b1);           // pause until everything is back
        est_slots = 5;

        // Random part: mostly positions among handed-out nodes, some noise
        for (int i = 0; i < RANDOM_CMDS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                op = alle_pkg::OP_INS_HEAD;
            else if (pick < 60)
                op = alle_pkg::OP_INS_AFTER;
            else if (pick < 85)
                op = alle_pkg::OP_DEL_AFTER;
            else
                op = alle_pkg::OP_TRAVERSE;
            if ($urandom_range(0, 4) == 0)
                pos = $urandom_range(0, SLOTS - 1);
            else
                pos = $urandom_range((op == alle_pkg::OP_INS_AFTER) ? 1 : 0,
                                     (est_slots < SLOTS - 1) ? est_slots : SLOTS - 1);
            if (op == alle_pkg::OP_INS_HEAD || op == alle_pkg::OP_INS_AFTER)
                est_slots++;
            add_cmd(op, pos, $urandom, ($urandom_range(0, 39) == 0));
        end
        // finish with a walk over whatever is left
        add_cmd(alle_pkg::OP_TRAVERSE, 0, 0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the queue to empty and every prediction to be matched
        timed_out = 1'b0;
        while (pending_cmds.size() > 0 || start || list_resp_q.size() > 0) begin
            @(negedge i_clk);
            if (idle_cycles >= IDLE_LIMIT) begin
                timed_out = 1'b1;
                break;
            end
        end
        if (!timed_out)
            repeat (TAIL_CYCLES) @(negedge i_clk);

        if (list_resp_q.size() > 0) begin
            err_count++;
            $display("%0d predicted results never arrived", list_resp_q.size());
        end
        if (err_count > SHOW_ERRORS)
            $display("%0d mismatches in total", err_count);

        $display("Transfers: %0d insert-head, %0d insert-after, %0d delete, %0d traverse",
                 op_count[alle_pkg::OP_INS_HEAD], op_count[alle_pkg::OP_INS_AFTER],
                 op_count[alle_pkg::OP_DEL_AFTER], op_count[alle_pkg::OP_TRAVERSE]);
        $display("Results: %0d (ok %0d, full %0d, bad position %0d, empty %0d), longest walk %0d",
                 resp_count, status_count[alle_pkg::ST_OK], status_count[alle_pkg::ST_FULL],
                 status_count[alle_pkg::ST_BADPOS], status_count[alle_pkg::ST_EMPTY],
                 longest_walk);

        if (!timed_out && err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/alle_pkg.sv
hw/rtl/alle_ram.sv
hw/rtl/alle_front.sv
hw/rtl/alle_queue.sv
hw/rtl/alle_back.sv
hw/rtl/array_linked_list_engine.sv
test/array_linked_list_engine_tb.sv
